// ----- design/signed_int_to_decimal_ascii_unit_assert.svh -----
// Assertion macros for the decimal text converter datapath
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define SIDA_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define SIDA_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);

`endif

// ----- design/sida_pkg.sv -----
// Shared types and constants for the signed integer to decimal text converter
package sida_pkg;

  // Value and stream widths
  localparam int VALUE_WIDTH = 64;
  localparam int IN_DATA_W   = 64;
  localparam int CHAR_W      = 8;

  // Decimal digits needed for an unsigned VALUE_WIDTH-bit magnitude
  localparam int DIGITS = ((VALUE_WIDTH * 1233) >>> 12) + 1;
  localparam int BCD_W  = DIGITS * 4;
  localparam int CNT_W  = $clog2(VALUE_WIDTH);
  localparam int IDX_W  = $clog2(DIGITS);

  // Character codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

  // Register file
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_OUTPUT_ENABLED = 1'b0;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic conv_step;
    logic push_sign;
    logic push_digit;
    logic skip_digit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic conv_done;
    logic neg;
    logic lead_zero;
    logic last_digit;
    logic out_free;
  } sts_t;

endpackage

// ----- design/sida_ctrl.sv -----
// Controller state machine: sequences load, conversion, sign and digit output
module sida_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic           output_enabled,
  input  sida_pkg::sts_t sts,
  output sida_pkg::cmd_t cmd
);
  import sida_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        // a beat taken while output is disabled is simply dropped
        if (s_tvalid && output_enabled) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (sts.conv_done) state_next = sts.neg ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (sts.out_free) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.last_digit && sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_CONV: cmd.conv_step = 1'b1;
      ST_SIGN: cmd.push_sign = sts.out_free;
      ST_EMIT: begin
        cmd.skip_digit = sts.lead_zero;
        cmd.push_digit = !sts.lead_zero && sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- design/sida_dp.sv -----
// Datapath: magnitude, shift-add-3 BCD conversion, digit shifter, output register
`include "signed_int_to_decimal_ascii_unit_assert.svh"

module sida_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [sida_pkg::IN_DATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sida_pkg::CHAR_W-1:0]    m_tdata,
  output logic                           m_tlast,
  input  sida_pkg::cmd_t                 cmd,
  output sida_pkg::sts_t                 sts
);
  import sida_pkg::*;

  logic [VALUE_WIDTH-1:0] mag;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_adj;
  logic                   neg;
  logic [CNT_W-1:0]       cnt;
  logic [IDX_W-1:0]       idx;
  logic                   started;
  logic [VALUE_WIDTH-1:0] v_in;
  logic [3:0]             top_digit;

  assign v_in      = s_tdata[VALUE_WIDTH-1:0];
  assign top_digit = bcd[BCD_W-1 -: 4];

  // Add 3 to every BCD digit of 5 or more ahead of the shift
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      bcd_adj[d*4 +: 4] = (bcd[d*4 +: 4] >= 4'd5) ? (bcd[d*4 +: 4] + 4'd3)
                                                  : bcd[d*4 +: 4];
    end
  end

  // Conversion and digit registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg     <= v_in[VALUE_WIDTH-1];
      mag     <= v_in[VALUE_WIDTH-1] ? (~v_in + VALUE_WIDTH'(1)) : v_in;
      bcd     <= '0;
      cnt     <= '0;
      idx     <= IDX_W'(DIGITS - 1);
      started <= 1'b0;
    end else if (cmd.conv_step) begin
      bcd <= {bcd_adj[BCD_W-2:0], mag[VALUE_WIDTH-1]};
      mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
      cnt <= cnt + CNT_W'(1);
    end else if (cmd.push_digit || cmd.skip_digit) begin
      // most significant digit always sits at the top
      bcd <= {bcd[BCD_W-5:0], 4'b0000};
      idx <= idx - IDX_W'(1);
      if (cmd.push_digit) started <= 1'b1;
    end
  end

  // Output register: one beat held until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.push_sign || cmd.push_digit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_sign) begin
      m_tdata <= CH_MINUS;
      m_tlast <= 1'b0;
    end else if (cmd.push_digit) begin
      m_tdata <= CH_ZERO + {4'b0000, top_digit};
      m_tlast <= (idx == '0);
    end
  end

  // Status
  assign sts.conv_done  = (cnt == CNT_W'(VALUE_WIDTH - 1));
  assign sts.neg        = neg;
  assign sts.lead_zero  = (top_digit == 4'd0) && !started && (idx != '0);
  assign sts.last_digit = (idx == '0);
  assign sts.out_free   = !m_tvalid || m_tready;

  // Checks
  `SIDA_ASSERT_IMP(a_push_into_free, (cmd.push_sign || cmd.push_digit),
                   (!m_tvalid || m_tready), "beat pushed over an untaken beat")
  `SIDA_ASSERT_IMP(a_char_legal, m_tvalid,
                   (m_tdata == CH_MINUS || (m_tdata >= CH_ZERO && m_tdata <= CH_NINE)),
                   "illegal character code")
  `SIDA_ASSERT_IMP(a_minus_not_last, (m_tvalid && m_tdata == CH_MINUS), !m_tlast,
                   "minus sign marked as last")
  `SIDA_ASSERT_NXT(a_digit_after_start, (cmd.push_digit && !cmd.load), started,
                   "digit pushed without start flag following")

endmodule

// ----- design/signed_int_to_decimal_ascii_unit.sv -----
// Top level: signed integer to decimal ASCII converter with APB register
// Usage:
//   s_tvalid/s_tready/s_tdata take one signed 64-bit value per beat.
//   m_tvalid/m_tready/m_tdata/m_tlast give its decimal text, one ASCII
//   character per beat, most significant first, '-' ahead of negatives,
//   no leading zeros, m_tlast on the final character.
//   Register output_enabled (address 0) gates all output; when 0 each value
//   is taken and gives no characters.
// Sequence: a value is taken in the idle state, then the shift-add-3
//   conversion loop runs, a sign character follows when negative, and
//   then the 20 digit positions are emitted (leading zeros skipped, one
//   per cycle unless the output stalls), most significant first.
// Stalls: characters pass through a one-beat output register; while it
//   holds a beat and m_tready is low the digit cycles wait, and no new value
//   is taken until the last character has been loaded into that register.
// Reset: rst (synchronous, active high) returns to idle, empties the output
//   register and clears output_enabled.
module signed_int_to_decimal_ascii_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sida_pkg::IN_DATA_W-1:0]  s_tdata,   // [63:0] value (signed)
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sida_pkg::CHAR_W-1:0]     m_tdata,   // [7:0] char_code
  output logic                            m_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sida_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sida_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sida_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import sida_pkg::*;

  logic output_enabled;
  cmd_t cmd;
  sts_t sts;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_enabled <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == REG_OUTPUT_ENABLED)) begin
      output_enabled <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_OUTPUT_ENABLED) prdata[0] = output_enabled;
  end

  // Controller
  sida_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .output_enabled (output_enabled),
    .sts            (sts),
    .cmd            (cmd)
  );

  // Datapath
  sida_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// ----- tb/tb_signed_int_to_decimal_ascii_unit.sv -----
// Testbench for the signed integer to decimal ASCII converter: stream and APB stimulus, text check
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii_unit;
  import sida_pkg::*;

  // Register map and run control
  localparam logic [APB_ADDR_W-1:0] ADDR_OUTPUT_ENABLED = APB_ADDR_W'(4 * REG_OUTPUT_ENABLED);
  localparam logic [APB_ADDR_W-1:0] ADDR_OUT_OF_RANGE   = APB_ADDR_W'(4);
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT   = 4000;  // cycles with no beat or APB access before giving up
  localparam int HOLD_AT_BEAT  = 400;
  localparam int HOLD_CYCLES   = 400;
  localparam logic [63:0] MAX_VALUE = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_VALUE = 64'h8000_0000_0000_0000;

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              is_last;
  } char_beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;     // [63:0] value
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [CHAR_W-1:0]     m_tdata;          // [7:0] char_code
  logic                  m_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic [63:0]  pending_values [$];
  char_beat_t   expected_chars [$];
  logic         text_enabled = 1'b0;
  logic         fast_mode = 1'b0;
  int unsigned  send_wait = 0;
  int unsigned  sink_wait = 0;
  int unsigned  char_beats = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  errors = 0;

  signed_int_to_decimal_ascii_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Idle cycles before the next beat: half the time none at all, never any in fast mode
  function automatic int unsigned draw_wait();
    if (fast_mode || $urandom_range(0, 1) == 0) begin
      return 0;
    end
    return $urandom_range(1, 16);
  endfunction

  // Decimal text of one accepted value, most significant character first; none while output is off
  function automatic void predict_text(input logic [63:0] value);
    logic [63:0] mag;
    logic [3:0]  digits [$];
    char_beat_t  c;
    if (!text_enabled) begin
      return;
    end
    mag = value[63] ? (~value + 64'd1) : value;
    do begin
      digits.push_front(4'(mag % 64'd10));
      mag = mag / 64'd10;
    end while (mag != 0);
    if (value[63]) begin
      c.code    = CH_MINUS;
      c.is_last = 1'b0;
      expected_chars.push_back(c);
    end
    foreach (digits[i]) begin
      c.code    = CH_ZERO + CHAR_W'(digits[i]);
      c.is_last = (i == digits.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  // Random value biased towards digit-count boundaries and the extremes
  function automatic logic [63:0] rand_value();
    logic [63:0] r;
    logic [63:0] p;
    int          k;
    r = {$urandom, $urandom};
    k = $urandom_range(1, 19);
    p = 64'd1;
    repeat (k) p = p * 64'd10;
    case ($urandom_range(0, 5))
      0: return r;
      1: r = r % 64'd1000;
      2: r = r % p;
      3: r = (k == 19) ? 64'd1 : p - 64'($urandom_range(0, 1));
      4: return $urandom_range(0, 1) ? MAX_VALUE - 64'($urandom_range(0, 2))
                                     : MIN_VALUE + 64'($urandom_range(0, 2));
      default: return r;
    endcase
    if ($urandom_range(0, 1)) begin
      r = -r;
    end
    return r;
  endfunction

  // Input side: offer queued values, predict the text of each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid  <= 1'b0;
      send_wait <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_text(s_tdata);
      end
      if (!s_tvalid || s_tready) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          s_tvalid  <= 1'b0;
        end else if (pending_values.size() != 0) begin
          s_tdata   <= pending_values.pop_front();
          s_tvalid  <= 1'b1;
          send_wait <= draw_wait();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each character beat, random stalls and one long hold-off
  always @(posedge clk) begin
    int unsigned wait_n;
    char_beat_t  exp_c;
    if (rst) begin
      m_tready  <= 1'b0;
      sink_wait <= 0;
    end else begin
      wait_n = sink_wait;
      if (m_tvalid && m_tready) begin
        if (expected_chars.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual char %0d last %0b",
                   $time, m_tdata, m_tlast);
        end else begin
          exp_c = expected_chars.pop_front();
          if (m_tdata !== exp_c.code) begin
            errors++;
            $display("%0t: char_code mismatch, expected %0d, actual %0d",
                     $time, exp_c.code, m_tdata);
          end
          if (m_tlast !== exp_c.is_last) begin
            errors++;
            $display("%0t: last_char mismatch, expected %0b, actual %0b",
                     $time, exp_c.is_last, m_tlast);
          end
        end
        char_beats++;
        wait_n = (char_beats == HOLD_AT_BEAT) ? HOLD_CYCLES : draw_wait();
      end else if (wait_n != 0) begin
        wait_n--;
      end
      sink_wait <= wait_n;
      m_tready  <= (wait_n == 0);
    end
  end

  // Watchdog on cycles without any beat or register access
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // One APB transfer: setup cycle, then access until pready
  task automatic apb_transfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data,
                              output logic [APB_DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    logic [APB_DATA_W-1:0] unused;
    apb_transfer(1'b1, addr, data, unused);
    // only bit 0 of the one register is kept
    if ((addr >> 2) == REG_OUTPUT_ENABLED) begin
      text_enabled = data[0];
    end
  endtask

  task automatic check_reg();
    logic [APB_DATA_W-1:0] rdata;
    apb_transfer(1'b0, ADDR_OUTPUT_ENABLED, '0, rdata);
    if (rdata !== APB_DATA_W'(text_enabled)) begin
      errors++;
      $display("%0t: output_enabled read mismatch, expected %0d, actual %0d",
               $time, text_enabled, rdata);
    end
  endtask

  // Wait for all values taken and all characters out, then let the block settle
  task automatic drain();
    while (pending_values.size() != 0 || s_tvalid || expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset value: output off, values are swallowed
    check_reg();
    pending_values = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd42, MIN_VALUE, MAX_VALUE};
    drain();

    // Out-of-range address and upper data bits are ignored
    write_reg(ADDR_OUT_OF_RANGE, 32'h0000_0001);
    check_reg();
    write_reg(ADDR_OUTPUT_ENABLED, 32'hFFFF_FFFE);
    check_reg();
    write_reg(ADDR_OUTPUT_ENABLED, 32'h0000_0001);
    check_reg();

    // Directed: zero, single digits, decade boundaries, extremes
    pending_values = '{
      64'd0, 64'd1, -64'd1, 64'd9, 64'd10, -64'd9, -64'd10, 64'd99, 64'd100,
      MAX_VALUE, MIN_VALUE, MIN_VALUE + 64'd1,
      64'd999_999_999_999_999_999, 64'd1_000_000_000_000_000_000,
      -64'd1_000_000_000_000_000_000, 64'd12_345_678_901_234_567,
      -64'd1_234_567_890, 64'd255, -64'd128, 64'd4_294_967_296
    };
    drain();

    // Random values with random idling on both sides
    repeat (155) pending_values.push_back(rand_value());
    drain();

    // Back-to-back, no idling
    fast_mode = 1'b1;
    repeat (40) pending_values.push_back(rand_value());
    drain();
    fast_mode = 1'b0;

    // Output off again
    write_reg(ADDR_OUTPUT_ENABLED, 32'hAAAA_AAAA);
    check_reg();
    repeat (20) pending_values.push_back(rand_value());
    drain();

    write_reg(ADDR_OUTPUT_ENABLED, 32'h8000_0001);
    check_reg();
    repeat (40) pending_values.push_back(rand_value());
    drain();

    if (expected_chars.size() != 0) begin
      errors++;
      $display("%0t: %0d characters never arrived", $time, expected_chars.size());
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
